// File: hdl/srdd_pkg.sv
// ----------------------------------------------------------------------------
// srdd_pkg
// Shared types, constants and the report unscramble function for the sensor
// report decrypt/decode core.
// ----------------------------------------------------------------------------
package srdd_pkg;

  localparam logic [7:0] TRAILER_BYTE = 8'h0d;
  localparam logic [7:0] TYPE_CO2     = 8'h50;
  localparam logic [7:0] TYPE_TEMP    = 8'h42;
  localparam logic [7:0] TYPE_HUM     = 8'h44;
  localparam logic signed [19:0] KELVIN_OFFSET_CENTI = 20'sd27315;

  localparam logic REG_SESSION_KEY = 1'b0;

  localparam logic [7:0] SALT_SWAP [8] = '{8'h84, 8'h47, 8'h56, 8'hd6,
                                           8'h07, 8'h93, 8'h93, 8'h56};
  localparam logic [2:0] BYTE_DEST [8] = '{3'd2, 3'd4, 3'd0, 3'd7,
                                           3'd1, 3'd6, 3'd5, 3'd3};

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TRAILER  = 2'd1,
    STAT_CHECKSUM = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CO2  = 2'd1,
    KIND_TEMP = 2'd2,
    KIND_HUM  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [63:0] plain;
    logic [15:0] value;
    status_t     status;
    kind_t       kind;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  function automatic logic [63:0] unscramble(input logic [63:0] cipher,
                                             input logic [63:0] key);
    logic [7:0]  moved [8];
    logic [7:0]  mixed [8];
    logic [7:0]  rot;
    logic [63:0] plain;
    for (int k = 0; k < 8; k++) begin
      moved[BYTE_DEST[k]] = cipher[8*k +: 8];
    end
    for (int k = 0; k < 8; k++) begin
      mixed[k] = moved[k] ^ key[8*k +: 8];
    end
    plain = '0;
    for (int k = 0; k < 8; k++) begin
      rot = {mixed[(k + 7) % 8][2:0], mixed[k][7:3]};
      plain[8*k +: 8] = rot - SALT_SWAP[k];
    end
    return plain;
  endfunction

endpackage

// File: hdl/srdd_front.sv
// ----------------------------------------------------------------------------
// srdd_front
// Decrypts an incoming report and classifies it: trailer and checksum checks,
// reading type and 16-bit value.
// ----------------------------------------------------------------------------
module srdd_front
  import srdd_pkg::*;
(
  input  logic [63:0] report,
  input  logic [63:0] key,
  output entry_t      entry
);

  logic [63:0] plain;
  logic [7:0]  sum;

  always_comb begin
    plain = unscramble(report, key);
    sum   = plain[7:0] + plain[15:8] + plain[23:16];
    entry.plain  = plain;
    entry.value  = {plain[15:8], plain[23:16]};
    entry.status = STAT_OK;
    entry.kind   = KIND_NONE;
    if (plain[39:32] != TRAILER_BYTE) begin
      entry.status = STAT_TRAILER;
    end else if (sum != plain[31:24]) begin
      entry.status = STAT_CHECKSUM;
    end else begin
      unique case (plain[7:0])
        TYPE_CO2:  entry.kind = KIND_CO2;
        TYPE_TEMP: entry.kind = KIND_TEMP;
        TYPE_HUM:  entry.kind = KIND_HUM;
        default:   entry.kind = KIND_NONE;
      endcase
    end
  end

endmodule

// File: hdl/srdd_queue.sv
// ----------------------------------------------------------------------------
// srdd_queue
// Two-entry queue of classified words between the front and back parts.
// ----------------------------------------------------------------------------
module srdd_queue
  import srdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  entry_t   push_data,
  input  logic     pop,
  output entry_t   pop_data,
  output q_flags_t flags
);

  entry_t      mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign pop_data    = mem[rd_ptr];
  assign flags.full  = (count == 2'd2);
  assign flags.empty = (count == 2'd0);

endmodule

// File: hdl/srdd_back.sv
// ----------------------------------------------------------------------------
// srdd_back
// Applies classified words to the reading stores and holds the result word.
// ----------------------------------------------------------------------------
module srdd_back
  import srdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  entry_t             entry,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [1:0]         kind,
  output logic [15:0]        raw_value,
  output logic [63:0]        plain_report,
  output logic [15:0]        co2_ppm,
  output logic               co2_valid,
  output logic signed [19:0] temp_centi_c,
  output logic               temp_valid,
  output logic [15:0]        hum_centi_pct,
  output logic               hum_valid
);

  logic [20:0]        t25;
  logic [18:0]        tq;
  logic signed [19:0] temp_next;

  assign pop = !q_empty && (!result_valid || !result_stall);

  // (t*25 + 2) / 4 - 27315
  always_comb begin
    t25       = {1'b0, entry.value, 4'b0} + {2'b0, entry.value, 3'b0}
              + {5'b0, entry.value} + 21'd2;
    tq        = t25[20:2];
    temp_next = $signed({1'b0, tq}) - KELVIN_OFFSET_CENTI;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      co2_ppm       <= '0;
      co2_valid     <= 1'b0;
      temp_centi_c  <= -KELVIN_OFFSET_CENTI;
      temp_valid    <= 1'b0;
      hum_centi_pct <= '0;
      hum_valid     <= 1'b0;
    end else begin
      if (pop) begin
        result_valid <= 1'b1;
        case (entry.kind)
          KIND_CO2: begin
            co2_ppm   <= entry.value;
            co2_valid <= 1'b1;
          end
          KIND_TEMP: begin
            temp_centi_c <= temp_next;
            temp_valid   <= 1'b1;
          end
          KIND_HUM: begin
            hum_centi_pct <= entry.value;
            hum_valid     <= 1'b1;
          end
          default: ;
        endcase
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status       <= entry.status;
      kind         <= entry.kind;
      raw_value    <= entry.value;
      plain_report <= entry.plain;
    end
  end

endmodule

// File: hdl/sensor_report_decrypt_decode_core.sv
// ----------------------------------------------------------------------------
// sensor_report_decrypt_decode_core
// Decrypts 8-byte sensor reports, checks them and keeps the last CO2,
// temperature and humidity readings.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  report    report_valid/report_stall    report
//  result    result_valid/result_stall    status .. hum_valid
//  config    APB write, 8*i addressing    session_key at 0x0
//
//  One report per cycle sustained while result_stall is low; a report passes through the queue, then the result reg.
//  Decrypt and checks sit in front of a 2-word queue; report_stall is the
//  queue full flag. Stores update when a word moves to the result register.
//  Synchronous reset clears stores, flags and key; temperature shows -27315.
module sensor_report_decrypt_decode_core
  import srdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               report_valid,
  output logic               report_stall,
  input  logic [63:0]        report,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [1:0]         kind,
  output logic [15:0]        raw_value,
  output logic [63:0]        plain_report,
  output logic [15:0]        co2_ppm,
  output logic               co2_valid,
  output logic signed [19:0] temp_centi_c,
  output logic               temp_valid,
  output logic [15:0]        hum_centi_pct,
  output logic               hum_valid
);

  logic [63:0] session_key;
  entry_t      front_entry;
  entry_t      back_entry;
  q_flags_t    q_flags;
  logic        push;
  logic        pop;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_SESSION_KEY) ? session_key : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_key <= '0;
    end else if (psel && penable && pwrite && pready && paddr[3] == REG_SESSION_KEY) begin
      session_key <= pwdata;
    end
  end

  assign report_stall = q_flags.full;
  assign push         = report_valid && !report_stall;

  srdd_front u_front (
    .report (report),
    .key    (session_key),
    .entry  (front_entry)
  );

  srdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_entry),
    .pop       (pop),
    .pop_data  (back_entry),
    .flags     (q_flags)
  );

  srdd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_flags.empty),
    .entry         (back_entry),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .kind          (kind),
    .raw_value     (raw_value),
    .plain_report  (plain_report),
    .co2_ppm       (co2_ppm),
    .co2_valid     (co2_valid),
    .temp_centi_c  (temp_centi_c),
    .temp_valid    (temp_valid),
    .hum_centi_pct (hum_centi_pct),
    .hum_valid     (hum_valid)
  );

  a_kind_needs_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (kind == KIND_NONE || status == STAT_OK))
    else $error("reading kind on a rejected report");

  a_temp_flag_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(temp_valid) |-> (result_valid && kind == KIND_TEMP))
    else $error("temp_valid rose without a temperature word");

  a_co2_store: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_CO2) |-> (co2_valid && co2_ppm == raw_value))
    else $error("CO2 store does not match reported value");

endmodule

// File: tb/sv/sensor_report_decrypt_decode_core_test.sv
// ----------------------------------------------------------------------------
// sensor_report_decrypt_decode_core_test
// Drives encrypted sensor reports into the decrypt/decode core under several
// session keys and checks every result word against a local decoder model.
// Both sides idle and stall at random; well-formed reports are built by
// encrypting chosen plain reports, mixed with corrupt reports and noise.
// ----------------------------------------------------------------------------
module sensor_report_decrypt_decode_core_test;
  import srdd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          KELVIN_CENTI = 27315;
  localparam logic [3:0]  ADDR_KEY     = 4'(REG_SESSION_KEY) * 4'd8;
  localparam logic [3:0]  ADDR_UNUSED  = 4'd8;
  localparam logic [7:0]  SALT [8]     = '{8'h48, 8'h74, 8'h65, 8'h6d,
                                           8'h70, 8'h39, 8'h39, 8'h65};
  localparam int          SHUFFLE [8]  = '{2, 4, 0, 7, 1, 6, 5, 3};

  typedef struct {
    status_t            st;
    kind_t              kd;
    logic [15:0]        raw;
    logic [63:0]        plain;
    logic [15:0]        co2;
    logic               co2_ok;
    logic signed [19:0] temp;
    logic               temp_ok;
    logic [15:0]        hum;
    logic               hum_ok;
  } reading_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;
  logic               report_valid;
  logic               report_stall;
  logic [63:0]        report;
  logic               result_valid;
  logic               result_stall;
  logic [1:0]         status;
  logic [1:0]         kind;
  logic [15:0]        raw_value;
  logic [63:0]        plain_report;
  logic [15:0]        co2_ppm;
  logic               co2_valid;
  logic signed [19:0] temp_centi_c;
  logic               temp_valid;
  logic [15:0]        hum_centi_pct;
  logic               hum_valid;

  logic [63:0] key_now;
  logic [15:0] co2_last;
  logic [15:0] temp_raw_last;
  logic [15:0] hum_last;
  logic [2:0]  seen_flags;
  reading_t    awaited_readings [$];
  int          errors;
  int          cycle_count;
  bit          jitter_on;

  sensor_report_decrypt_decode_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .report_valid(report_valid), .report_stall(report_stall), .report(report),
    .result_valid(result_valid), .result_stall(result_stall),
    .status(status), .kind(kind), .raw_value(raw_value),
    .plain_report(plain_report), .co2_ppm(co2_ppm), .co2_valid(co2_valid),
    .temp_centi_c(temp_centi_c), .temp_valid(temp_valid),
    .hum_centi_pct(hum_centi_pct), .hum_valid(hum_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout", $time);
    $display("status: fail");
    $finish;
  end

  function automatic logic [7:0] salt_swapped(int k);
    return {SALT[k][3:0], SALT[k][7:4]};
  endfunction

  function automatic logic [63:0] decrypt_report(logic [63:0] cipher, logic [63:0] key);
    logic [7:0]  keyed [8];
    logic [63:0] plain;
    for (int k = 0; k < 8; k++) begin
      keyed[SHUFFLE[k]] = cipher[8*k +: 8];
    end
    for (int k = 0; k < 8; k++) begin
      keyed[k] = keyed[k] ^ key[8*k +: 8];
    end
    for (int k = 0; k < 8; k++) begin
      plain[8*k +: 8] = {keyed[(k + 7) % 8][2:0], keyed[k][7:3]} - salt_swapped(k);
    end
    return plain;
  endfunction

  function automatic logic [63:0] encrypt_report(logic [63:0] plain, logic [63:0] key);
    logic [7:0]  rot [8];
    logic [7:0]  keyed [8];
    logic [63:0] cipher;
    for (int k = 0; k < 8; k++) begin
      rot[k] = plain[8*k +: 8] + salt_swapped(k);
    end
    for (int k = 0; k < 8; k++) begin
      keyed[k] = {rot[k][4:0], rot[(k + 1) % 8][7:5]} ^ key[8*k +: 8];
    end
    for (int k = 0; k < 8; k++) begin
      cipher[8*k +: 8] = keyed[SHUFFLE[k]];
    end
    return cipher;
  endfunction

  // plain report: type, value big-endian, checksum, trailer, random filler
  function automatic logic [63:0] build_plain(logic [7:0] kind_byte, logic [15:0] value,
                                              bit bad_trailer, bit bad_sum);
    logic [7:0] sum;
    logic [7:0] tail;
    sum = kind_byte + value[15:8] + value[7:0];
    tail = TRAILER_BYTE;
    if (bad_trailer) begin
      do tail = 8'($urandom); while (tail == TRAILER_BYTE);
    end
    if (bad_sum) sum = sum + 8'($urandom_range(255, 1));
    return {24'($urandom), tail, sum, value[7:0], value[15:8], kind_byte};
  endfunction

  function automatic logic [63:0] sealed(logic [7:0] kind_byte, logic [15:0] value,
                                         bit bad_trailer = 0, bit bad_sum = 0);
    return encrypt_report(build_plain(kind_byte, value, bad_trailer, bad_sum), key_now);
  endfunction

  function automatic void decode_report(logic [63:0] cipher);
    reading_t   w;
    logic [63:0] plain;
    int         centi;
    plain = decrypt_report(cipher, key_now);
    w.plain = plain;
    w.raw = {plain[15:8], plain[23:16]};
    w.kd = KIND_NONE;
    if (plain[39:32] != TRAILER_BYTE) begin
      w.st = STAT_TRAILER;
    end else if (8'(plain[7:0] + plain[15:8] + plain[23:16]) != plain[31:24]) begin
      w.st = STAT_CHECKSUM;
    end else begin
      w.st = STAT_OK;
      case (plain[7:0])
        TYPE_CO2: begin
          w.kd = KIND_CO2;
          co2_last = w.raw;
          seen_flags[0] = 1'b1;
        end
        TYPE_TEMP: begin
          w.kd = KIND_TEMP;
          temp_raw_last = w.raw;
          seen_flags[1] = 1'b1;
        end
        TYPE_HUM: begin
          w.kd = KIND_HUM;
          hum_last = w.raw;
          seen_flags[2] = 1'b1;
        end
        default: ;
      endcase
    end
    centi = (int'(temp_raw_last) * 25 + 2) / 4 - KELVIN_CENTI;
    w.co2 = co2_last;
    w.co2_ok = seen_flags[0];
    w.temp = 20'(centi);
    w.temp_ok = seen_flags[1];
    w.hum = hum_last;
    w.hum_ok = seen_flags[2];
    awaited_readings.push_back(w);
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    reading_t w;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_readings.size() == 0) begin
        $display("%0t: unexpected word, expected none actual plain %0h", $time,
                 plain_report);
        errors++;
      end else begin
        w = awaited_readings.pop_front();
        compare_field("status", 64'(w.st), 64'(status));
        compare_field("kind", 64'(w.kd), 64'(kind));
        compare_field("raw_value", 64'(w.raw), 64'(raw_value));
        compare_field("plain_report", w.plain, plain_report);
        compare_field("co2_ppm", 64'(w.co2), 64'(co2_ppm));
        compare_field("co2_valid", 64'(w.co2_ok), 64'(co2_valid));
        compare_field("temp_centi_c", 64'(unsigned'(w.temp)), 64'(unsigned'(temp_centi_c)));
        compare_field("temp_valid", 64'(w.temp_ok), 64'(temp_valid));
        compare_field("hum_centi_pct", 64'(w.hum), 64'(hum_centi_pct));
        compare_field("hum_valid", 64'(w.hum_ok), 64'(hum_valid));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= jitter_on && ($urandom_range(99) < 31);
  end

  task automatic send_report(input logic [63:0] cipher);
    if (jitter_on) begin
      while ($urandom_range(99) < 31) begin
        report_valid <= 1'b0;
        report <= {$urandom, $urandom};
        @(negedge clk);
      end
    end
    report_valid <= 1'b1;
    report <= cipher;
    do @(posedge clk); while (report_stall);
    decode_report(cipher);
    @(negedge clk);
  endtask

  task automatic drain;
    report_valid <= 1'b0;
    while (awaited_readings.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_KEY) key_now = data;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_reset_state;
    send_report(64'h0);
    send_report('1);
  endtask

  task automatic test_bit_patterns;
    send_report(64'haaaa_aaaa_aaaa_aaaa);
    send_report(64'h5555_5555_5555_5555);
  endtask

  task automatic test_reading_types;
    send_report(sealed(TYPE_CO2, 16'h0000));
    send_report(sealed(TYPE_CO2, 16'hffff));
    send_report(sealed(TYPE_TEMP, 16'h0000));
    send_report(sealed(TYPE_TEMP, 16'hffff));
    send_report(sealed(TYPE_HUM, 16'h0000));
    send_report(sealed(TYPE_HUM, 16'hffff));
    send_report(sealed(8'h00, 16'h1234));
  endtask

  task automatic test_corrupt_reports;
    send_report(sealed(TYPE_CO2, 16'h0321, 1, 0));
    send_report(sealed(TYPE_TEMP, 16'h1280, 1, 0));
    send_report(sealed(TYPE_HUM, 16'h0fa0, 0, 1));
    send_report(sealed(TYPE_CO2, 16'h04d2, 0, 1));
    send_report(sealed(TYPE_TEMP, 16'h12c0, 1, 1));
  endtask

  task automatic test_key_writes;
    write_reg(ADDR_KEY, '1);
    send_report(sealed(TYPE_CO2, 16'h07d0));
    write_reg(ADDR_UNUSED, {$urandom, $urandom});
    send_report(sealed(TYPE_HUM, 16'h1388));
    write_reg(ADDR_KEY, 64'h0);
    send_report(sealed(TYPE_TEMP, 16'h1200));
  endtask

  task automatic test_random_stream(input logic [63:0] key, input int count,
                                    input bit jitter);
    int         pick;
    logic [7:0] kind_byte;
    write_reg(ADDR_KEY, key);
    jitter_on = jitter;
    repeat (count) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0: kind_byte = TYPE_CO2;
        1: kind_byte = TYPE_TEMP;
        2: kind_byte = TYPE_HUM;
        default: kind_byte = 8'($urandom);
      endcase
      if (pick < 70) send_report(sealed(kind_byte, 16'($urandom)));
      else if (pick < 80) send_report(sealed(kind_byte, 16'($urandom), 1, 0));
      else if (pick < 90) send_report(sealed(kind_byte, 16'($urandom), 0, 1));
      else send_report({$urandom, $urandom});
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    errors = 0;
    jitter_on = 1'b1;
    key_now = '0;
    co2_last = '0;
    temp_raw_last = '0;
    hum_last = '0;
    seen_flags = '0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    report_valid = 1'b0;
    report = '0;
    result_stall = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_bit_patterns();
    test_reading_types();
    test_corrupt_reports();
    test_key_writes();
    test_random_stream({$urandom, $urandom}, 160, 1);
    test_random_stream(64'h0, 160, 1);
    test_random_stream('1, 160, 0);
    test_random_stream({$urandom, $urandom}, 160, 1);

    drain();
    repeat (5) @(posedge clk);
    if (awaited_readings.size() != 0) begin
      $display("%0t: %0d words never arrived", $time, awaited_readings.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
